### rtl/c2p_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the chunky-to-planar scanline writer.
// No dependencies; every other file of the block imports this package.
package c2p_pkg;

	localparam int MAX_LINE_PIXELS = 2048;
	localparam int ADDR_BITS       = 20;
	localparam int LW_W            = 12;
	localparam int COORD_W         = 11;
	localparam int COLOR_W         = 4;
	localparam int NUM_PLANES      = 4;
	localparam int PROD_W          = COORD_W + LW_W;
	localparam int SUM_W           = ADDR_BITS + 3;
	localparam int OUT_ADDR_W      = 20;
	localparam int BANK_SHIFT      = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	localparam logic [LW_W-1:0] LINE_WIDTH_RESET = LW_W'(640);
	localparam logic [LW_W-1:0] LINE_WIDTH_MAX   = LW_W'(MAX_LINE_PIXELS);
	localparam logic [2:0]      LAST_BIT_POS     = 3'd7;
	localparam logic [7:0]      LEFT_BIT         = 8'h80;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [COORD_W-1:0] start_column;
		logic [COORD_W-1:0] row;
		logic               first;
		logic               last;
	} pix_t;

	typedef struct packed {
		logic [7:0]            plane_zero;
		logic [7:0]            plane_one;
		logic [7:0]            plane_two;
		logic [7:0]            plane_three;
		logic [7:0]            bit_enable;
		logic [OUT_ADDR_W-1:0] byte_address;
		logic [3:0]            bank;
		logic [15:0]           bank_offset;
		logic                  end_of_segment;
	} res_t;

	// One classified pixel as it waits between the front and the back.
	typedef struct packed {
		logic [COLOR_W-1:0]   color;
		logic [2:0]           col_lsb;
		logic                 first;
		logic                 last;
		logic [ADDR_BITS-1:0] addr;
	} qent_t;

endpackage

### rtl/c2p_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixels in and plane bytes out.
// Depends on c2p_pkg for the payload types.
interface c2p_pix_if;
	import c2p_pkg::*;
	logic valid;
	logic ready;
	pix_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface c2p_res_if;
	import c2p_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/c2p_front.sv
`timescale 1ns / 1ps
// Front end: takes pixels, holds the line width and works out segment start addresses.
// Depends on c2p_pkg and c2p_if.
module c2p_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [c2p_pkg::LW_W-1:0]  cfg_wdata,
	c2p_pix_if.sink                   pixel,
	input  logic                      q_full,
	output logic                      q_push,
	output c2p_pkg::qent_t            q_wdata
);
	import c2p_pkg::*;

	logic [LW_W-1:0]   line_width_q;
	logic [LW_W-1:0]   width_sat;
	logic              valid_s1;
	pix_t              pix_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [SUM_W-1:0]  sum;
	logic              in_fire;

	assign width_sat    = (line_width_q > LINE_WIDTH_MAX) ? LINE_WIDTH_MAX : line_width_q;
	assign pixel.ready  = !valid_s1 || !q_full;
	assign in_fire      = pixel.valid && pixel.ready;
	assign q_push       = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				line_width_q <= cfg_wdata;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1  <= pixel.data;
			prod_s1 <= PROD_W'(pixel.data.row) * PROD_W'(width_sat);
		end
	end

	// Pixel offset of the segment start; dropping its low three bits gives the byte address.
	assign sum = SUM_W'(prod_s1) + SUM_W'(pix_s1.start_column);

	always_comb begin
		q_wdata.color   = pix_s1.color;
		q_wdata.col_lsb = pix_s1.start_column[2:0];
		q_wdata.first   = pix_s1.first;
		q_wdata.last    = pix_s1.last;
		q_wdata.addr    = sum[SUM_W-1:3];
	end

endmodule

### rtl/c2p_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue between the front end and the packer.
// Depends on c2p_pkg for the entry type and depth.
module c2p_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  c2p_pkg::qent_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output c2p_pkg::qent_t rdata
);
	import c2p_pkg::*;

	qent_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### rtl/c2p_back.sv
`timescale 1ns / 1ps
// Back end: packs pixels into four plane bytes and drives the registered result.
// Depends on c2p_pkg and c2p_if.
module c2p_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  c2p_pkg::qent_t q_data,
	output logic           q_pop,
	c2p_res_if.source      result
);
	import c2p_pkg::*;

	logic [7:0]           acc_q [NUM_PLANES];
	logic [7:0]           mask_q;
	logic [2:0]           bit_pos_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic [7:0]           acc_new [NUM_PLANES];
	logic [7:0]           mask_new;
	logic [2:0]           pos;
	logic [ADDR_BITS-1:0] addr_cur;
	logic [7:0]           bit_sel;
	logic                 full;
	logic                 emit;

	assign q_pop = q_valid && (!res_valid_q || result.ready);

	// A first pixel restarts the byte at the start column's bit.
	always_comb begin
		pos      = q_data.first ? q_data.col_lsb : bit_pos_q;
		addr_cur = q_data.first ? q_data.addr : addr_q;
		bit_sel  = LEFT_BIT >> pos;
		for (int k = 0; k < NUM_PLANES; k++) begin
			acc_new[k] = (q_data.first ? 8'h00 : acc_q[k])
				| (q_data.color[k] ? bit_sel : 8'h00);
		end
		mask_new = (q_data.first ? 8'h00 : mask_q) | bit_sel;
		full     = (pos == LAST_BIT_POS);
		emit     = full || q_data.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PLANES; k++) begin
				acc_q[k] <= 8'h00;
			end
			mask_q      <= 8'h00;
			bit_pos_q   <= 3'd0;
			addr_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop && emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				bit_pos_q <= pos + 3'd1;
				if (emit) begin
					for (int k = 0; k < NUM_PLANES; k++) begin
						acc_q[k] <= 8'h00;
					end
					mask_q <= 8'h00;
					addr_q <= full ? addr_cur + 1'b1 : addr_cur;
				end else begin
					for (int k = 0; k < NUM_PLANES; k++) begin
						acc_q[k] <= acc_new[k];
					end
					mask_q <= mask_new;
					addr_q <= addr_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_q.plane_zero     <= acc_new[0];
			res_q.plane_one      <= acc_new[1];
			res_q.plane_two      <= acc_new[2];
			res_q.plane_three    <= acc_new[3];
			res_q.bit_enable     <= mask_new;
			res_q.byte_address   <= OUT_ADDR_W'(addr_cur);
			res_q.bank           <= 4'(addr_cur >> BANK_SHIFT);
			res_q.bank_offset    <= addr_cur[BANK_SHIFT-1:0];
			res_q.end_of_segment <= q_data.last;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

### rtl/chunky_to_planar_scanline_writer_core.sv
`timescale 1ns / 1ps
// Top level of the chunky-to-planar scanline writer: front end, queue and packer.
// Depends on c2p_pkg, c2p_if, c2p_front, c2p_queue and c2p_back.

// This block turns a stream of 4-bit pixels into 16-color planar memory writes. Each
// segment starts with a pixel marked first, which carries the start column and row; the
// block then emits one result per plane byte: four plane bytes (leftmost pixel in bit 7,
// color bit k on plane k), a bit-enable mask of the new pixels, the linear byte address
// (row * line_width + column) / 8, and that address split into a 64 KiB bank and offset.
// A byte goes out when its bit 0 is filled or when the pixel marked last arrives, so the
// first byte of a segment is right-aligned and the last one left-aligned. The block takes
// one pixel per clock for as long as the result side keeps up. A pixel passes through the
// front stage register, which holds the row-times-width product, and a queue slot, from
// whose head the packer loads the result register directly. The four-entry queue lets the
// front keep accepting while the result side stalls, until the queue is full. Line widths
// above 2048 are treated as 2048; line_width is written through cfg_we and cfg_wdata and
// resets to 640. The user must write it only while the block is idle; the block itself
// does not enforce this.
module chunky_to_planar_scanline_writer_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [c2p_pkg::LW_W-1:0] cfg_wdata,
	c2p_pix_if.sink                  pixel,
	c2p_res_if.source                result
);
	import c2p_pkg::*;

	// Queue handshake between the front end and the packer.
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_not_empty;
	qent_t q_wdata;
	qent_t q_rdata;

	// The front end registers each transfer and computes the segment's start address.
	c2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	c2p_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	// The packer pops a pixel whenever its result register is free or being emptied.
	c2p_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

### rtl/c2p_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the scanline writer, bound to the top level.
// Depends on c2p_pkg and chunky_to_planar_scanline_writer_core.
module c2p_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input c2p_pkg::res_t res_data
);
	import c2p_pkg::*;

	// A result that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// Bank and offset are the two halves of the byte address.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.bank == res_data.byte_address[19:16])
			&& (res_data.bank_offset == res_data.byte_address[15:0]))
		else $error("bank or offset disagrees with byte address");

	// Every emitted byte carries at least one new pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.bit_enable != 8'h00))
		else $error("result with empty bit enable");

	// Plane bits can only be set where a new pixel was written.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (((res_data.plane_zero | res_data.plane_one | res_data.plane_two
			| res_data.plane_three) & ~res_data.bit_enable) == 8'h00))
		else $error("plane bit set outside bit enable");

endmodule

bind chunky_to_planar_scanline_writer_core c2p_checker u_c2p_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
